>>> design/isojac_pkg.sv
// ----------------------------------------------------------------------------
// isojac_pkg
// Shared constants, index tables and fixed-point helpers for the 3D element
// Jacobian block.
// ----------------------------------------------------------------------------
`default_nettype none
package isojac_pkg;

	typedef logic [3:0] idx9_t;
	typedef logic [1:0] axis_t;

	localparam int NUM_J = 9;

	// adjugate entry k = J[a0]*J[b0] - J[a1]*J[b1]
	localparam idx9_t ADJ_A0 [NUM_J] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
	localparam idx9_t ADJ_B0 [NUM_J] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
	localparam idx9_t ADJ_A1 [NUM_J] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
	localparam idx9_t ADJ_B1 [NUM_J] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

	// jacobian entry k: coordinate axis and reference axis
	localparam axis_t COORD_AXIS [NUM_J] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
	localparam axis_t REF_AXIS   [NUM_J] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

	localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
	localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;

	// shift right 16 toward zero, saturate to 64 bits
	function automatic logic signed [63:0] wide_to64(input logic signed [127:0] x);
		logic [127:0] mag;
		logic [111:0] sh;
		logic signed [63:0] r;
		mag = x[127] ? 128'(-x) : 128'(x);
		sh = mag[127:16];
		if (sh[111:63] != '0) begin
			r = x[127] ? MIN64 : MAX64;
		end else begin
			r = x[127] ? -$signed({1'b0, sh[62:0]}) : $signed({1'b0, sh[62:0]});
		end
		return r;
	endfunction

	// shift right 16 toward zero, saturate to 32 bits
	function automatic logic signed [31:0] sat_shr16(input logic signed [63:0] v);
		logic [63:0] mag;
		logic [47:0] m;
		logic signed [31:0] r;
		mag = v[63] ? 64'(-v) : 64'(v);
		m = mag[63:16];
		if (m[47:31] != '0) begin
			r = v[63] ? MIN32 : MAX32;
		end else begin
			r = v[63] ? -$signed({1'b0, m[30:0]}) : $signed({1'b0, m[30:0]});
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/isoparametric_jacobian_3d.sv
// ----------------------------------------------------------------------------
// isoparametric_jacobian_3d
// Fixed-point Jacobian, determinant, inverse and physical shape derivatives
// of one 3D isoparametric element, computed on a shared multiplier.
// ----------------------------------------------------------------------------
// usage
//   input channel: one node per beat, taken on a clock edge with start high
//   and busy low. a node that is not marked last is summed into the
//   jacobian (nine products on the shared multiplier) and then busy
//   drops. a node beyond NODES stored nodes is dropped.
//   on the last node the block also forms the adjugate, the determinant,
//   the volume, nine inverse entries on a one-bit-per-cycle divider (all
//   zero if the determinant is zero) and then one result row per stored
//   node.
//   result channel: valid is high for exactly one cycle per row; the
//   receiver cannot stall, so each row must be taken in that cycle.
//   last_row marks the final row; busy drops in the cycle after it.
//   throughput is set by the shared 32x32 multiplier and the serial divider.
//   reset: asynchronous, active low; clears the sums, node count and
//   control. stored derivatives and the inverse hold no reset value.
// ----------------------------------------------------------------------------
`default_nettype none
module isoparametric_jacobian_3d #(
	parameter int NODES = 8
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire signed  [31:0] coord_x,
	input  wire signed  [31:0] coord_y,
	input  wire signed  [31:0] coord_z,
	input  wire signed  [19:0] deriv_r,
	input  wire signed  [19:0] deriv_s,
	input  wire signed  [19:0] deriv_t,
	input  wire         [19:0] gauss_weight,
	input  wire                last_node,
	output logic               valid,
	output logic signed [31:0] phys_dx,
	output logic signed [31:0] phys_dy,
	output logic signed [31:0] phys_dz,
	output logic signed [63:0] jacobian_det,
	output logic signed [63:0] volume,
	output logic               singular,
	output logic        [2:0]  node_index,
	output logic               last_row
);

	localparam int CW = $clog2(NODES + 1);
	localparam int PW = $clog2(NODES);

	typedef enum logic [3:0] {
		S_IDLE, S_OPA, S_OPB, S_MUL, S_ADD, S_STORE, S_JQ,
		S_DIV_INIT, S_DIV, S_DIV_END, S_DONE
	} state_t;

	typedef enum logic [2:0] {
		JOB_NODE, JOB_ADJ, JOB_DET, JOB_VOL, JOB_ROW
	} job_t;

	state_t state_q;
	job_t   job_q;

	// element storage
	logic signed [19:0] ref_derivs [NODES][3];
	logic signed [31:0] c_q [3];
	logic signed [19:0] d_q [3];
	logic signed [63:0] jacc_q [9];
	logic signed [31:0] j_q [9];
	logic signed [63:0] adj_q [9];
	logic signed [31:0] inv_q [9];
	logic signed [63:0] det_q;
	logic               sing_q;
	logic        [19:0] weight_q;
	logic               last_q;
	logic [CW-1:0]      node_count_q;
	logic [PW-1:0]      p_q;
	logic [3:0]         k_q;
	logic [1:0]         term_q;

	// shared multiplier
	logic [63:0]         ma_q, mb_q;
	logic                mneg_q, ahi_q, bhi_q, ca_q, cb_q;
	logic [63:0]         pp_q;
	logic signed [127:0] acc_q;

	// serial divider
	logic [79:0] nsh_q;
	logic [63:0] dmag_q, r_q;
	logic [32:0] q_q;
	logic        over_q, dneg_q;
	logic [6:0]  bit_q;

	// operand fetch
	logic signed [63:0] opa, opb;
	logic [3:0]         row_inv_idx;
	logic [1:0]         last_term;

	assign row_inv_idx = 4'(term_q) * 4'd3 + k_q;

	always_comb begin
		opa = '0;
		opb = '0;
		last_term = 2'd0;
		case (job_q)
			JOB_NODE: begin
				opa = 64'(c_q[isojac_pkg::COORD_AXIS[k_q]]);
				opb = 64'(d_q[isojac_pkg::REF_AXIS[k_q]]);
			end
			JOB_ADJ: begin
				opa = 64'(j_q[term_q[0] ? isojac_pkg::ADJ_A1[k_q] : isojac_pkg::ADJ_A0[k_q]]);
				opb = 64'(j_q[term_q[0] ? isojac_pkg::ADJ_B1[k_q] : isojac_pkg::ADJ_B0[k_q]]);
				last_term = 2'd1;
			end
			JOB_DET: begin
				opa = 64'(j_q[4'(term_q)]);
				opb = adj_q[4'(term_q) * 4'd3];
				last_term = 2'd2;
			end
			JOB_VOL: begin
				opa = det_q;
				opb = $signed({44'd0, weight_q});
			end
			JOB_ROW: begin
				opa = 64'(ref_derivs[p_q][term_q]);
				opb = 64'(inv_q[row_inv_idx]);
				last_term = 2'd2;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// partial product and its placement
	logic [31:0]  a_chunk, b_chunk;
	logic [127:0] pp_ext;
	assign a_chunk = ca_q ? ma_q[63:32] : ma_q[31:0];
	assign b_chunk = cb_q ? mb_q[63:32] : mb_q[31:0];

	always_comb begin
		case ({ca_q, cb_q})
			2'b00:   pp_ext = {64'd0, pp_q};
			2'b11:   pp_ext = {pp_q, 64'd0};
			default: pp_ext = {32'd0, pp_q, 32'd0};
		endcase
	end

	logic signed [63:0] acc_sat64;
	logic signed [31:0] acc_q16;
	assign acc_sat64 = isojac_pkg::wide_to64(acc_q);
	assign acc_q16   = isojac_pkg::sat_shr16(acc_q[63:0]);

	// divider step: one quotient bit per cycle
	logic [64:0] r_next;
	logic        q_bit;
	logic [32:0] q_next;
	logic        q_big;
	assign r_next = {r_q, nsh_q[79]};
	assign q_bit  = r_next >= {1'b0, dmag_q};
	assign q_next = {q_q[31:0], q_bit};
	assign q_big  = over_q | q_q[32] | q_q[31];

	logic signed [31:0] div_res;
	always_comb begin
		if (dneg_q) begin
			div_res = q_big ? isojac_pkg::MIN32 : -$signed({1'b0, q_q[30:0]});
		end else begin
			div_res = q_big ? isojac_pkg::MAX32 : $signed({1'b0, q_q[30:0]});
		end
	end

	logic last_emit;
	assign last_emit = (CW'(p_q) == node_count_q - CW'(1));

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			job_q        <= JOB_NODE;
			node_count_q <= '0;
			weight_q     <= '0;
			last_q       <= 1'b0;
			valid        <= 1'b0;
			k_q          <= '0;
			term_q       <= '0;
			p_q          <= '0;
			for (int i = 0; i < 9; i++) begin
				jacc_q[i] <= '0;
			end
		end else begin
			// a row beat goes out when its third column is stored
			valid <= (state_q == S_STORE) && (job_q == JOB_ROW) && (k_q == 4'd2);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						last_q <= last_node;
						if (last_node) begin
							weight_q <= gauss_weight;
						end
						if (node_count_q < CW'(NODES)) begin
							ref_derivs[node_count_q[PW-1:0]] <= '{deriv_r, deriv_s, deriv_t};
							c_q    <= '{coord_x, coord_y, coord_z};
							d_q    <= '{deriv_r, deriv_s, deriv_t};
							job_q  <= JOB_NODE;
							k_q    <= '0;
							term_q <= '0;
							state_q <= S_OPA;
						end else if (last_node) begin
							state_q <= S_JQ;
						end
					end
				end
				S_OPA: begin
					ma_q   <= opa[63] ? 64'(-opa) : 64'(opa);
					ahi_q  <= (opa[63] ? 64'(-opa) : 64'(opa)) >= 64'h1_0000_0000;
					mneg_q <= opa[63];
					if (term_q == 2'd0) begin
						acc_q <= (job_q == JOB_NODE) ? 128'(jacc_q[k_q]) : '0;
					end
					state_q <= S_OPB;
				end
				S_OPB: begin
					mb_q   <= opb[63] ? 64'(-opb) : 64'(opb);
					bhi_q  <= (opb[63] ? 64'(-opb) : 64'(opb)) >= 64'h1_0000_0000;
					mneg_q <= mneg_q ^ opb[63] ^ (job_q == JOB_ADJ && term_q[0]);
					ca_q   <= 1'b0;
					cb_q   <= 1'b0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					pp_q    <= a_chunk * b_chunk;
					state_q <= S_ADD;
				end
				S_ADD: begin
					acc_q <= mneg_q ? acc_q - $signed(pp_ext) : acc_q + $signed(pp_ext);
					if (!cb_q && bhi_q) begin
						cb_q    <= 1'b1;
						state_q <= S_MUL;
					end else if (!ca_q && ahi_q) begin
						ca_q    <= 1'b1;
						cb_q    <= 1'b0;
						state_q <= S_MUL;
					end else if (term_q != last_term) begin
						term_q  <= term_q + 2'd1;
						state_q <= S_OPA;
					end else begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					term_q <= '0;
					case (job_q)
						JOB_NODE: begin
							jacc_q[k_q] <= acc_q[63:0];
							if (k_q == 4'd8) begin
								node_count_q <= node_count_q + CW'(1);
								state_q <= last_q ? S_JQ : S_IDLE;
							end else begin
								k_q     <= k_q + 4'd1;
								state_q <= S_OPA;
							end
						end
						JOB_ADJ: begin
							adj_q[k_q] <= acc_q[63:0];
							if (k_q == 4'd8) begin
								k_q   <= '0;
								job_q <= JOB_DET;
							end else begin
								k_q <= k_q + 4'd1;
							end
							state_q <= S_OPA;
						end
						JOB_DET: begin
							det_q   <= acc_sat64;
							sing_q  <= (acc_sat64 == '0);
							job_q   <= JOB_VOL;
							state_q <= S_OPA;
						end
						JOB_VOL: begin
							volume  <= acc_sat64;
							k_q     <= '0;
							state_q <= S_DIV_INIT;
						end
						JOB_ROW: begin
							if (k_q == 4'd0) begin
								phys_dx <= acc_q16;
								k_q     <= 4'd1;
								state_q <= S_OPA;
							end else if (k_q == 4'd1) begin
								phys_dy <= acc_q16;
								k_q     <= 4'd2;
								state_q <= S_OPA;
							end else begin
								phys_dz      <= acc_q16;
								jacobian_det <= det_q;
								singular     <= sing_q;
								node_index   <= 3'(p_q);
								last_row     <= last_emit;
								k_q          <= '0;
								if (last_emit) begin
									node_count_q <= '0;
									for (int i = 0; i < 9; i++) begin
										jacc_q[i] <= '0;
									end
									state_q <= S_DONE;
								end else begin
									p_q     <= p_q + PW'(1);
									state_q <= S_OPA;
								end
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_JQ: begin
					for (int i = 0; i < 9; i++) begin
						j_q[i] <= isojac_pkg::sat_shr16(jacc_q[i]);
					end
					job_q   <= JOB_ADJ;
					k_q     <= '0;
					term_q  <= '0;
					state_q <= S_OPA;
				end
				S_DIV_INIT: begin
					if (sing_q) begin
						inv_q[k_q] <= '0;
						if (k_q == 4'd8) begin
							job_q   <= JOB_ROW;
							k_q     <= '0;
							p_q     <= '0;
							state_q <= S_OPA;
						end else begin
							k_q <= k_q + 4'd1;
						end
					end else begin
						nsh_q   <= {(adj_q[k_q][63] ? 64'(-adj_q[k_q]) : 64'(adj_q[k_q])), 16'd0};
						dmag_q  <= det_q[63] ? 64'(-det_q) : 64'(det_q);
						dneg_q  <= adj_q[k_q][63] ^ det_q[63];
						r_q     <= '0;
						q_q     <= '0;
						over_q  <= 1'b0;
						bit_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					r_q   <= q_bit ? 64'(r_next - {1'b0, dmag_q}) : r_next[63:0];
					nsh_q <= {nsh_q[78:0], 1'b0};
					if (!over_q) begin
						q_q    <= q_next;
						over_q <= q_next[32];
					end
					bit_q <= bit_q + 7'd1;
					if (bit_q == 7'd79) begin
						state_q <= S_DIV_END;
					end
				end
				S_DIV_END: begin
					inv_q[k_q] <= div_res;
					if (k_q == 4'd8) begin
						job_q   <= JOB_ROW;
						k_q     <= '0;
						p_q     <= '0;
						state_q <= S_OPA;
					end else begin
						k_q     <= k_q + 4'd1;
						state_q <= S_DIV_INIT;
					end
				end
				S_DONE: begin
					p_q     <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> design/isojac_checker.sv
// ----------------------------------------------------------------------------
// isojac_checker
// Port-level checks of the row sequencing of the element Jacobian block.
// ----------------------------------------------------------------------------
`default_nettype none
module isojac_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               start,
	input wire               busy,
	input wire               valid,
	input wire               last_row,
	input wire               singular,
	input wire signed [31:0] phys_dx,
	input wire signed [31:0] phys_dy,
	input wire signed [31:0] phys_dz,
	input wire signed [63:0] volume
);

	// the block stays idle until a beat arrives
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> !busy) else $error("busy without a beat");

	// rows only come out while an element is in flight
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> busy) else $error("row beat outside busy");

	// a row that is not the last leaves the block busy, with no back-to-back row
	a_more_rows: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last_row |=> busy && !valid) else $error("row sequence broken");

	// element ends right after its last row
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last_row |=> !busy && !valid) else $error("busy after last row");

	// a singular element gives zero derivatives and volume
	a_singular: assert property (@(posedge clk) disable iff (!arst_n)
		valid && singular |-> phys_dx == 0 && phys_dy == 0 && phys_dz == 0 && volume == 0)
		else $error("singular row not zero");

endmodule

bind isoparametric_jacobian_3d isojac_checker u_isojac_checker (.*);
`default_nettype wire

>>> bench/isoparametric_jacobian_3d_test.sv
// ----------------------------------------------------------------------------
// isoparametric_jacobian_3d_test
// Self-checking bench for the 3D element Jacobian block: element nodes are
// queued by a stimulus block and driven one beat at a time. A bit-exact
// predictor works out the result rows per element, and a monitor compares
// every result beat field by field against the oldest predicted row.
// ----------------------------------------------------------------------------
`default_nettype none
module isoparametric_jacobian_3d_test;

	localparam int NODES = 8;

	typedef struct {
		logic signed [31:0] cx, cy, cz;
		logic signed [19:0] dr, ds, dt;
		logic        [19:0] weight;
		logic               last_flag;
		logic               drain;     // hold off until all rows have come
		logic               quiet;     // no idle bursts before this node
	} node_t;

	typedef struct {
		logic signed [31:0] dx, dy, dz;
		logic signed [63:0] det, vol;
		logic               sing;
		logic        [2:0]  idx;
		logic               last_flag;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
	logic signed [19:0] deriv_r = '0, deriv_s = '0, deriv_t = '0;
	logic        [19:0] gauss_weight = '0;
	logic               last_node = 1'b0;
	logic valid;
	logic signed [31:0] phys_dx, phys_dy, phys_dz;
	logic signed [63:0] jacobian_det, volume;
	logic singular;
	logic [2:0] node_index;
	logic last_row;

	isoparametric_jacobian_3d #(.NODES(NODES)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.deriv_r(deriv_r), .deriv_s(deriv_s), .deriv_t(deriv_t),
		.gauss_weight(gauss_weight), .last_node(last_node),
		.valid(valid), .phys_dx(phys_dx), .phys_dy(phys_dy), .phys_dz(phys_dz),
		.jacobian_det(jacobian_det), .volume(volume), .singular(singular),
		.node_index(node_index), .last_row(last_row)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor state: stored derivatives and exact jacobian sums
	// ------------------------------------------------------------------
	node_t node_queue[$];
	row_t  row_queue[$];
	int    error_count = 0;

	logic signed [19:0] held_deriv [NODES][3];
	logic signed [63:0] jac_sum [9];
	int                 stored_nodes = 0;

	// magnitude shifted right 16, sign put back: rounds toward zero
	function automatic logic signed [127:0] shr16_tz(input logic signed [127:0] v);
		logic [127:0] m;
		m = v[127] ? -v : v;
		m = m >> 16;
		return v[127] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
		if (v > 128'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -128'sh8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] clamp64(input logic signed [127:0] v);
		if (v > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (v < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return v[63:0];
	endfunction

	// adj * 2^16 / det toward zero, saturated to Q16.16
	function automatic logic signed [31:0] inv_entry(input logic signed [127:0] adj,
			input logic signed [127:0] det);
		logic [127:0] num, den, q;
		logic neg;
		neg = adj[127] != det[127];
		num = (adj[127] ? -adj : adj) << 16;
		den = det[127] ? -det : det;
		q = num / den;
		if (!neg) return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
		if (q >= 128'h8000_0000) return 32'sh8000_0000;
		return -$signed(q[31:0]);
	endfunction

	// one accepted node: sum it in and, on the last node, predict the rows
	task automatic absorb_node(input node_t n);
		logic signed [127:0] crd [3];
		logic signed [127:0] drv [3];
		logic signed [127:0] jm [9];
		logic signed [127:0] adj [9];
		logic signed [127:0] dsum, det_w, sum_w;
		logic signed [63:0]  det, vol;
		logic signed [31:0]  inv [9];
		logic signed [31:0]  phys [3];
		logic sing;
		row_t r;
		crd[0] = n.cx; crd[1] = n.cy; crd[2] = n.cz;
		drv[0] = n.dr; drv[1] = n.ds; drv[2] = n.dt;
		// nodes past NODES are dropped entirely
		if (stored_nodes < NODES) begin
			held_deriv[stored_nodes][0] = n.dr;
			held_deriv[stored_nodes][1] = n.ds;
			held_deriv[stored_nodes][2] = n.dt;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					jac_sum[i*3+j] = jac_sum[i*3+j] + 64'(drv[j] * crd[i]);
			stored_nodes++;
		end
		if (!n.last_flag) return;
		for (int k = 0; k < 9; k++) jm[k] = clamp32(shr16_tz(jac_sum[k]));
		adj[0] = jm[4]*jm[8] - jm[5]*jm[7];
		adj[1] = jm[2]*jm[7] - jm[1]*jm[8];
		adj[2] = jm[1]*jm[5] - jm[2]*jm[4];
		adj[3] = jm[5]*jm[6] - jm[3]*jm[8];
		adj[4] = jm[0]*jm[8] - jm[2]*jm[6];
		adj[5] = jm[2]*jm[3] - jm[0]*jm[5];
		adj[6] = jm[3]*jm[7] - jm[4]*jm[6];
		adj[7] = jm[1]*jm[6] - jm[0]*jm[7];
		adj[8] = jm[0]*jm[4] - jm[1]*jm[3];
		dsum = jm[0]*adj[0] + jm[1]*adj[3] + jm[2]*adj[6];
		det = clamp64(shr16_tz(dsum));
		sing = (det == 0);
		det_w = det;
		vol = clamp64(shr16_tz(det_w * $signed({108'd0, n.weight})));
		for (int k = 0; k < 9; k++) inv[k] = sing ? 32'sd0 : inv_entry(adj[k], det_w);
		for (int p = 0; p < stored_nodes; p++) begin
			for (int i = 0; i < 3; i++) begin
				sum_w = 0;
				for (int j = 0; j < 3; j++)
					sum_w = sum_w + 64'($signed(held_deriv[p][j]) * inv[j*3+i]);
				phys[i] = clamp32(shr16_tz($signed(sum_w[63:0])));
			end
			r.dx = phys[0]; r.dy = phys[1]; r.dz = phys[2];
			r.det = det; r.vol = vol; r.sing = sing;
			r.idx = p[2:0];
			r.last_flag = (p == stored_nodes - 1);
			row_queue.push_back(r);
		end
		for (int k = 0; k < 9; k++) jac_sum[k] = '0;
		stored_nodes = 0;
	endtask

	task automatic flag_mismatch(input string msg);
		$display("mismatch @%0t: %s", $time, msg);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// driver: one node per beat, random idle bursts between beats
	// ------------------------------------------------------------------
	node_t cur_node;
	int    gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			// beat taken at this edge
			if (start && !busy) absorb_node(cur_node);
			if (!start || !busy) begin
				if (gap_left != 0) begin
					start <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (node_queue.size() == 0) begin
					start <= 1'b0;
				end else if (node_queue[0].drain && (row_queue.size() != 0 || busy)) begin
					// pressure: wait for the block to drain completely
					start <= 1'b0;
				end else if (!node_queue[0].quiet && $urandom_range(0, 5) == 0) begin
					start <= 1'b0;
					gap_left <= $urandom_range(0, 7);
				end else begin
					cur_node <= node_queue[0];
					coord_x <= node_queue[0].cx;
					coord_y <= node_queue[0].cy;
					coord_z <= node_queue[0].cz;
					deriv_r <= node_queue[0].dr;
					deriv_s <= node_queue[0].ds;
					deriv_t <= node_queue[0].dt;
					gauss_weight <= node_queue[0].weight;
					last_node <= node_queue[0].last_flag;
					node_queue.pop_front();
					start <= 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: every result beat against the oldest predicted row
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		row_t e;
		if (arst_n && valid) begin
			if (row_queue.size() == 0) begin
				flag_mismatch($sformatf("result row %0d with nothing expected", node_index));
			end else begin
				e = row_queue.pop_front();
				if (phys_dx !== e.dx)
					flag_mismatch($sformatf("phys_dx %h, want %h", phys_dx, e.dx));
				if (phys_dy !== e.dy)
					flag_mismatch($sformatf("phys_dy %h, want %h", phys_dy, e.dy));
				if (phys_dz !== e.dz)
					flag_mismatch($sformatf("phys_dz %h, want %h", phys_dz, e.dz));
				if (jacobian_det !== e.det)
					flag_mismatch($sformatf("jacobian_det %h, want %h", jacobian_det, e.det));
				if (volume !== e.vol)
					flag_mismatch($sformatf("volume %h, want %h", volume, e.vol));
				if (singular !== e.sing)
					flag_mismatch($sformatf("singular %b, want %b", singular, e.sing));
				if (node_index !== e.idx)
					flag_mismatch($sformatf("node_index %0d, want %0d", node_index, e.idx));
				if (last_row !== e.last_flag)
					flag_mismatch($sformatf("last_row %b, want %b", last_row, e.last_flag));
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	int item_total = 0;

	task automatic push_node(input logic signed [31:0] x, y, z,
			input logic signed [19:0] r, s, t, input logic [19:0] w,
			input logic lf, input logic dr = 1'b0);
		node_t n;
		n.cx = x; n.cy = y; n.cz = z;
		n.dr = r; n.ds = s; n.dt = t;
		n.weight = w; n.last_flag = lf; n.drain = dr;
		n.quiet = (item_total >= 180);
		node_queue.push_back(n);
		item_total++;
	endtask

	// mix of full-range and shortened magnitudes so that bits and saturation both show
	function automatic logic signed [31:0] rand_coord();
		logic signed [31:0] v;
		v = $urandom;
		if ($urandom_range(0, 3) != 0) v = v >>> $urandom_range(4, 20);
		return v;
	endfunction

	function automatic logic signed [19:0] rand_deriv();
		logic signed [19:0] v;
		v = 20'($urandom);
		if ($urandom_range(0, 2) == 0) v = v >>> $urandom_range(1, 12);
		return v;
	endfunction

	task automatic random_element(input int nodes);
		logic dr;
		dr = ($urandom_range(0, 7) == 0);
		for (int k = 0; k < nodes; k++)
			push_node(rand_coord(), rand_coord(), rand_coord(),
				rand_deriv(), rand_deriv(), rand_deriv(),
				20'($urandom), k == nodes - 1, (k == 0) && dr);
	endtask

	initial begin
		int nodes;
		for (int k = 0; k < 9; k++) jac_sum[k] = '0;

		// unit jacobian, full weight
		push_node(32'sh1_0000, 0, 0, 20'sh1_0000, '0, '0, '0, 1'b0);
		push_node(0, 32'sh1_0000, 0, '0, 20'sh1_0000, '0, '0, 1'b0);
		push_node(0, 0, 32'sh1_0000, '0, '0, 20'sh1_0000, 20'hFFFFF, 1'b1, 1'b1);
		// one node gives a rank-one jacobian: singular; waits for all rows first
		push_node(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, '0, 1'b1, 1'b1);
		push_node(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			20'sh80000, 20'sh80000, 20'sh80000, 20'hFFFFF, 1'b1);
		// saturated jacobian entries, mixed signs
		push_node(32'sh7FFF_FFFF, 0, 0, 20'sh7FFFF, '0, '0, 20'h12345, 1'b0);
		push_node(0, 32'sh8000_0000, 0, '0, 20'sh7FFFF, '0, 20'h12345, 1'b0);
		push_node(0, 0, 32'sh8000_0000, '0, '0, 20'sh80000, 20'hFFFFF, 1'b1);
		// tiny third axis: inverse entry saturates
		push_node(32'sh1_0000, 0, 0, 20'sh1_0000, '0, '0, '0, 1'b0);
		push_node(0, 32'sh1_0000, 0, '0, 20'sh1_0000, '0, '0, 1'b0);
		push_node(0, 0, 2, 20'sh7FFFF, 20'sh80000, 20'sh1_0000, 20'h10000, 1'b1);
		// nine nodes: the ninth, marked last, is dropped
		for (int k = 0; k < 9; k++)
			push_node(rand_coord(), rand_coord(), rand_coord(),
				rand_deriv(), rand_deriv(), rand_deriv(), 20'($urandom), k == 8);

		// random elements, mostly legal sizes, a few overfull
		while (item_total < 220) begin
			if ($urandom_range(0, 9) == 0) nodes = $urandom_range(9, 11);
			else nodes = $urandom_range(1, NODES);
			random_element(nodes);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (node_queue.size() != 0 || start || row_queue.size() != 0);
		repeat (200) @(posedge clk);
		if (row_queue.size() != 0)
			flag_mismatch($sformatf("%0d rows never arrived", row_queue.size()));
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog
	initial begin
		#30_000_000;
		$display("timeout");
		$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire

>>> isoparametric_jacobian_3d.f
design/isojac_pkg.sv
design/isoparametric_jacobian_3d.sv
design/isojac_checker.sv
bench/isoparametric_jacobian_3d_test.sv
